// ----- design/mswd_pkg.sv -----
package mswd_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W   = 3;
    localparam int SLOT_W  = 4;
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 2;
    localparam int CNT_W   = 5;
    localparam int IVL_W   = 16;

    localparam logic [IVL_W-1:0] INTERVAL_RESET = 16'd100;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_REG_TASK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNREG_TASK = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REG_PIPE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UNREG_PIPE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FEED_PIPE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd5;

    // Result kinds
    localparam logic [KIND_W-1:0] EV_STATUS     = 2'd0;
    localparam logic [KIND_W-1:0] EV_TASK_TMO   = 2'd1;
    localparam logic [KIND_W-1:0] EV_PIPE_STALL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TASK,
        ST_PIPE,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] timeout_ms;
        logic              has_cancel;
    } in_word_t;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [SLOT_W-1:0] event_slot;
        logic [TIME_W-1:0] elapsed_ms;
        logic              cancel_fired;
        logic [TIME_W-1:0] timeout_total;
        logic [CNT_W-1:0]  active_tasks;
        logic [CNT_W-1:0]  active_pipelines;
        logic              last;
    } out_word_t;

    // Table entries held in the slot memories
    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] limit;
        logic              cancel;
    } task_ent_t;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] limit;
    } pipe_ent_t;

endpackage

// ----- design/multi_slot_watchdog_unit.sv -----
// Multi-slot watchdog. Task and pipeline slots live in two single-port tables
// (one write or one registered read per cycle); valid bits and occupancy counts
// sit in flops. Register, unregister, feed and unused-code words each pass
// through ST_STATUS and give one status word. A tick advances the clock by the
// check interval, then walks every task slot and then every pipeline slot, one
// slot per cycle off the table read port, pausing on an expired slot while the
// previous word still waits on m_ready. A status word likewise waits until the
// previous word is taken. Each expired slot yields one word, and a final status
// word with last set closes every input word.
module multi_slot_watchdog_unit #(
    parameter int TASK_SLOTS = 16,
    parameter int PIPE_SLOTS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  mswd_pkg::in_word_t             s_data,

    output logic                           m_valid,
    input  logic                           m_ready,
    output mswd_pkg::out_word_t            m_data,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mswd_pkg::IVL_W-1:0]     cfg_data
);

    localparam int TIDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int PIDX_W = (PIPE_SLOTS > 1) ? $clog2(PIPE_SLOTS) : 1;
    localparam int MAXS   = (TASK_SLOTS > PIPE_SLOTS) ? TASK_SLOTS : PIPE_SLOTS;
    localparam int IDX_W  = (MAXS > 1) ? $clog2(MAXS) : 1;
    localparam int TW     = mswd_pkg::TIME_W;
    localparam int CW     = mswd_pkg::CNT_W;

    // Slot tables
    mswd_pkg::task_ent_t task_mem [TASK_SLOTS];
    mswd_pkg::pipe_ent_t pipe_mem [PIPE_SLOTS];

    // Control state
    mswd_pkg::state_t            state_reg, state_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [TW-1:0]               now_reg, now_next;
    logic [TW-1:0]               expiry_reg, expiry_next;
    logic [CW-1:0]               tcnt_reg, tcnt_next;
    logic [CW-1:0]               pcnt_reg, pcnt_next;
    logic [TASK_SLOTS-1:0]       tvalid_reg, tvalid_next;
    logic [PIPE_SLOTS-1:0]       pvalid_reg, pvalid_next;
    logic [mswd_pkg::IVL_W-1:0]  interval_reg;
    logic                        m_valid_reg, m_valid_next;
    mswd_pkg::out_word_t         m_data_reg, m_data_next;

    // Table ports
    mswd_pkg::task_ent_t         task_rd_reg, task_wdata;
    mswd_pkg::pipe_ent_t         pipe_rd_reg, pipe_wdata;
    logic                        task_rd_en, task_we;
    logic                        pipe_rd_en, pipe_we, pipe_feed_we;
    logic [TIDX_W-1:0]           task_raddr, cmd_taddr;
    logic [PIDX_W-1:0]           pipe_raddr, cmd_paddr;

    // Scratch
    logic                        accept, out_free, task_ok, pipe_ok;
    logic                        hit, scan_end;
    logic [TW-1:0]               elapsed;
    logic [TIDX_W-1:0]           scan_taddr;
    logic [PIDX_W-1:0]           scan_paddr;

    assign s_ready   = (state_reg == mswd_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cmd_taddr = TIDX_W'(s_data.slot);
    assign cmd_paddr = PIDX_W'(s_data.slot);
    assign task_ok   = 32'(s_data.slot) < TASK_SLOTS;
    assign pipe_ok   = 32'(s_data.slot) < PIPE_SLOTS;
    assign scan_taddr = idx_reg[TIDX_W-1:0];
    assign scan_paddr = idx_reg[PIDX_W-1:0];

    // Next state, table accesses and result word
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        now_next     = now_reg;
        expiry_next  = expiry_reg;
        tcnt_next    = tcnt_reg;
        pcnt_next    = pcnt_reg;
        tvalid_next  = tvalid_reg;
        pvalid_next  = pvalid_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        task_rd_en   = 1'b0;
        task_raddr   = '0;
        pipe_rd_en   = 1'b0;
        pipe_raddr   = '0;
        task_we      = 1'b0;
        pipe_we      = 1'b0;
        pipe_feed_we = 1'b0;
        task_wdata   = '{start: now_reg, limit: s_data.timeout_ms,
                         cancel: s_data.has_cancel};
        pipe_wdata   = '{stamp: now_reg, limit: s_data.timeout_ms};
        hit          = 1'b0;
        scan_end     = 1'b0;
        elapsed      = '0;

        unique case (state_reg)
            mswd_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = mswd_pkg::ST_STATUS;
                    unique case (s_data.command)
                        mswd_pkg::CMD_REG_TASK: begin
                            if (task_ok) begin
                                task_we = 1'b1;
                                tvalid_next[cmd_taddr] = 1'b1;
                                if (!tvalid_reg[cmd_taddr]) tcnt_next = tcnt_reg + 1'b1;
                            end
                        end
                        mswd_pkg::CMD_UNREG_TASK: begin
                            if (task_ok && tvalid_reg[cmd_taddr]) begin
                                tvalid_next[cmd_taddr] = 1'b0;
                                tcnt_next = tcnt_reg - 1'b1;
                            end
                        end
                        mswd_pkg::CMD_REG_PIPE: begin
                            if (pipe_ok) begin
                                pipe_we = 1'b1;
                                pvalid_next[cmd_paddr] = 1'b1;
                                if (!pvalid_reg[cmd_paddr]) pcnt_next = pcnt_reg + 1'b1;
                            end
                        end
                        mswd_pkg::CMD_UNREG_PIPE: begin
                            if (pipe_ok && pvalid_reg[cmd_paddr]) begin
                                pvalid_next[cmd_paddr] = 1'b0;
                                pcnt_next = pcnt_reg - 1'b1;
                            end
                        end
                        mswd_pkg::CMD_FEED_PIPE: begin
                            pipe_feed_we = pipe_ok && pvalid_reg[cmd_paddr];
                        end
                        mswd_pkg::CMD_TICK: begin
                            now_next   = now_reg + TW'(interval_reg);
                            state_next = mswd_pkg::ST_TASK;
                            idx_next   = '0;
                            task_rd_en = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end

            // Task scan: read data of idx_reg is in task_rd_reg
            mswd_pkg::ST_TASK: begin
                elapsed  = now_reg - task_rd_reg.start;
                hit      = tvalid_reg[scan_taddr] && (elapsed >= task_rd_reg.limit);
                scan_end = (32'(idx_reg) == TASK_SLOTS - 1);
                if (!hit || out_free) begin
                    if (hit) begin
                        tvalid_next[scan_taddr] = 1'b0;
                        tcnt_next    = tcnt_reg - 1'b1;
                        expiry_next  = expiry_reg + 1'b1;
                        m_valid_next = 1'b1;
                        m_data_next  = '{event_kind: mswd_pkg::EV_TASK_TMO,
                                         event_slot: mswd_pkg::SLOT_W'(idx_reg),
                                         elapsed_ms: elapsed,
                                         cancel_fired: task_rd_reg.cancel,
                                         timeout_total: expiry_reg + 1'b1,
                                         active_tasks: tcnt_reg - 1'b1,
                                         active_pipelines: pcnt_reg,
                                         last: 1'b0};
                    end
                    if (scan_end) begin
                        state_next = mswd_pkg::ST_PIPE;
                        idx_next   = '0;
                        pipe_rd_en = 1'b1;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        task_rd_en = 1'b1;
                        task_raddr = idx_next[TIDX_W-1:0];
                    end
                end
            end

            // Pipeline scan
            mswd_pkg::ST_PIPE: begin
                elapsed  = now_reg - pipe_rd_reg.stamp;
                hit      = pvalid_reg[scan_paddr] && (elapsed >= pipe_rd_reg.limit);
                scan_end = (32'(idx_reg) == PIPE_SLOTS - 1);
                if (!hit || out_free) begin
                    if (hit) begin
                        pvalid_next[scan_paddr] = 1'b0;
                        pcnt_next    = pcnt_reg - 1'b1;
                        m_valid_next = 1'b1;
                        m_data_next  = '{event_kind: mswd_pkg::EV_PIPE_STALL,
                                         event_slot: mswd_pkg::SLOT_W'(idx_reg),
                                         elapsed_ms: elapsed,
                                         cancel_fired: 1'b0,
                                         timeout_total: expiry_reg,
                                         active_tasks: tcnt_reg,
                                         active_pipelines: pcnt_reg - 1'b1,
                                         last: 1'b0};
                    end
                    if (scan_end) begin
                        state_next = mswd_pkg::ST_STATUS;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        pipe_rd_en = 1'b1;
                        pipe_raddr = idx_next[PIDX_W-1:0];
                    end
                end
            end

            // Closing status word
            mswd_pkg::ST_STATUS: begin
                if (out_free) begin
                    state_next   = mswd_pkg::ST_IDLE;
                    m_valid_next = 1'b1;
                    m_data_next  = '{event_kind: mswd_pkg::EV_STATUS,
                                     event_slot: '0,
                                     elapsed_ms: '0,
                                     cancel_fired: 1'b0,
                                     timeout_total: expiry_reg,
                                     active_tasks: tcnt_reg,
                                     active_pipelines: pcnt_reg,
                                     last: 1'b1};
                end
            end

            default: state_next = mswd_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mswd_pkg::ST_IDLE;
            now_reg      <= '0;
            expiry_reg   <= '0;
            tcnt_reg     <= '0;
            pcnt_reg     <= '0;
            tvalid_reg   <= '0;
            pvalid_reg   <= '0;
            m_valid_reg  <= 1'b0;
            interval_reg <= mswd_pkg::INTERVAL_RESET;
        end else begin
            state_reg   <= state_next;
            now_reg     <= now_next;
            expiry_reg  <= expiry_next;
            tcnt_reg    <= tcnt_next;
            pcnt_reg    <= pcnt_next;
            tvalid_reg  <= tvalid_next;
            pvalid_reg  <= pvalid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) interval_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        m_data_reg <= m_data_next;
    end

    // Task table
    always_ff @(posedge aclk) begin
        if (task_we) task_mem[cmd_taddr] <= task_wdata;
        if (task_rd_en) task_rd_reg <= task_mem[task_raddr];
    end

    // Pipeline table; feed rewrites the stamp only
    always_ff @(posedge aclk) begin
        if (pipe_we) pipe_mem[cmd_paddr] <= pipe_wdata;
        if (pipe_feed_we) pipe_mem[cmd_paddr].stamp <= now_reg;
        if (pipe_rd_en) pipe_rd_reg <= pipe_mem[pipe_raddr];
    end

endmodule

// ----- design/mswd_checker.sv -----
module mswd_checker #(
    parameter int TASK_SLOTS = 16,
    parameter int PIPE_SLOTS = 16
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input mswd_pkg::out_word_t m_data
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // No new input word while a tick still has results to give
    a_busy_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> !s_ready)
        else $error("input taken during tick scan");

    // Closing word is a clean status word
    a_status_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |-> m_data.event_kind == mswd_pkg::EV_STATUS &&
            m_data.event_slot == '0 && m_data.elapsed_ms == '0 && !m_data.cancel_fired)
        else $error("bad status word");

    // Intermediate words are expiries
    a_expiry_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> m_data.event_kind == mswd_pkg::EV_TASK_TMO ||
            m_data.event_kind == mswd_pkg::EV_PIPE_STALL)
        else $error("non-final word is not an expiry");

    // Occupancy never exceeds table size
    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_data.active_tasks) <= TASK_SLOTS &&
            32'(m_data.active_pipelines) <= PIPE_SLOTS)
        else $error("occupancy count out of range");

endmodule

bind multi_slot_watchdog_unit mswd_checker #(
    .TASK_SLOTS(TASK_SLOTS),
    .PIPE_SLOTS(PIPE_SLOTS)
) u_mswd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
